[hdl/fxa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxa_pkg: shared types and codes for the fixed-point ALU
// Operation codes, status codes and the packed request and result words.
// ----------------------------------------------------------------------------
package fxa_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_EQ = 4'd4, OP_NE = 4'd5, OP_LT = 4'd6, OP_GT = 4'd7,
        OP_LE = 4'd8, OP_GE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_flag;
        logic [1:0]         status;
    } t_out;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        logic               is_div;
        logic               is_mul;
        logic               neg;
        logic               b_zero;
        logic [31:0]        mag_a;
        logic [31:0]        mag_b;
        t_out               simple;
    } t_cls;

endpackage

[hdl/fxa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxa_front: request classifier
// Computes the simple operations and prepares magnitudes for mul/div.
// ----------------------------------------------------------------------------
module fxa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fxa_pkg::t_in  i_req,
    output logic          o_valid,
    output fxa_pkg::t_cls o_cls
);

    localparam logic signed [33:0] MAX34 = 34'sd2147483647;
    localparam logic signed [33:0] MIN34 = -34'sd2147483648;

    logic signed [33:0] sum;
    logic signed [63:0] shl;
    logic               shl_ovf;
    fxa_pkg::t_cls      cls;
    logic               r_valid;
    fxa_pkg::t_cls      r_cls;

    always_comb begin
        logic signed [33:0] a;
        logic signed [33:0] b;
        a = 34'(i_req.operand_a);
        b = 34'(i_req.operand_b);
        shl = 64'(i_req.operand_a) <<< FRAC_BITS;
        shl_ovf = (shl > 64'sd2147483647) || (shl < -64'sd2147483648);
        cls = '0;
        sum = '0;
        cls.mag_a = i_req.operand_a[31] ? 32'(-i_req.operand_a) : i_req.operand_a;
        cls.mag_b = i_req.operand_b[31] ? 32'(-i_req.operand_b) : i_req.operand_b;
        cls.neg = i_req.operand_a[31] ^ i_req.operand_b[31];
        cls.b_zero = (i_req.operand_b == 32'sd0);
        unique case (fxa_pkg::t_op'(i_req.operation))
            fxa_pkg::OP_ADD, fxa_pkg::OP_SUB, fxa_pkg::OP_INC, fxa_pkg::OP_DEC: begin
                priority case (fxa_pkg::t_op'(i_req.operation))
                    fxa_pkg::OP_ADD: sum = a + b;
                    fxa_pkg::OP_SUB: sum = a - b;
                    fxa_pkg::OP_INC: sum = a + 34'sd1;
                    default:         sum = a - 34'sd1;
                endcase
                if (sum > MAX34) begin
                    cls.simple.result_value = 32'sh7fffffff;
                    cls.simple.status = fxa_pkg::ST_OVF;
                end else if (sum < MIN34) begin
                    cls.simple.result_value = 32'sh80000000;
                    cls.simple.status = fxa_pkg::ST_OVF;
                end else begin
                    cls.simple.result_value = sum[31:0];
                end
            end
            fxa_pkg::OP_MUL: cls.is_mul = 1'b1;
            fxa_pkg::OP_DIV: cls.is_div = 1'b1;
            fxa_pkg::OP_EQ: cls.simple.compare_flag = (a == b);
            fxa_pkg::OP_NE: cls.simple.compare_flag = (a != b);
            fxa_pkg::OP_LT: cls.simple.compare_flag = (a < b);
            fxa_pkg::OP_GT: cls.simple.compare_flag = (a > b);
            fxa_pkg::OP_LE: cls.simple.compare_flag = (a <= b);
            fxa_pkg::OP_GE: cls.simple.compare_flag = (a >= b);
            fxa_pkg::OP_MIN: cls.simple.result_value =
                (a > b) ? i_req.operand_b : i_req.operand_a;
            fxa_pkg::OP_MAX: cls.simple.result_value =
                (a > b) ? i_req.operand_a : i_req.operand_b;
            fxa_pkg::OP_TO_INT: cls.simple.result_value = i_req.operand_a >>> FRAC_BITS;
            default: begin
                if (shl_ovf) begin
                    cls.simple.result_value = i_req.operand_a[31] ? 32'sh80000000
                                                                  : 32'sh7fffffff;
                    cls.simple.status = fxa_pkg::ST_OVF;
                end else begin
                    cls.simple.result_value = shl[31:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_cls <= cls;
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

endmodule

[hdl/fxa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxa_back: arithmetic pipeline
// Pipelined multiplier and radix-2 divider; one stage per quotient bit.
// ----------------------------------------------------------------------------
module fxa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fxa_pkg::t_cls i_cls,
    output logic          o_valid,
    output fxa_pkg::t_out o_res
);

    // Numerator is |a| << FRAC_BITS; the round bit comes from comparing 2r
    // against d once every quotient bit is retired.
    localparam int NW    = 32 + FRAC_BITS;
    localparam int DEPTH = NW + 2;

    typedef struct packed {
        logic          valid;
        logic          is_div;
        logic          is_mul;
        logic          neg;
        logic          b_zero;
        logic [31:0]   d;
        logic [NW-1:0] rem;
        logic [NW-1:0] num;
        logic [63:0]   prod;
        fxa_pkg::t_out simple;
    } t_stg;

    t_stg r_stg [DEPTH];
    t_stg n_stg [DEPTH];

    always_comb begin
        n_stg[0] = '0;
        n_stg[0].valid  = i_valid;
        n_stg[0].is_div = i_cls.is_div;
        n_stg[0].is_mul = i_cls.is_mul;
        n_stg[0].neg    = i_cls.neg;
        n_stg[0].b_zero = i_cls.b_zero;
        n_stg[0].d      = i_cls.mag_b;
        n_stg[0].num    = {i_cls.mag_a, {FRAC_BITS{1'b0}}};
        n_stg[0].simple = i_cls.simple;
        // Stage 1 multiplies the magnitudes.
        n_stg[1] = r_stg[0];
        n_stg[1].prod = 64'(r_stg[0].num[NW-1:FRAC_BITS]) * 64'(r_stg[0].d);
        // Stages 2..NW+1 each retire one quotient bit, MSB first.
        for (int k = 2; k < NW + 2; k++) begin
            logic [NW:0] trial;
            n_stg[k] = r_stg[k-1];
            trial = {r_stg[k-1].rem, r_stg[k-1].num[NW-1]};
            n_stg[k].num = {r_stg[k-1].num[NW-2:0], 1'b0};
            if (trial >= (NW+1)'(r_stg[k-1].d)) begin
                n_stg[k].rem = NW'(trial - (NW+1)'(r_stg[k-1].d));
                n_stg[k].num[0] = 1'b1;
            end else begin
                n_stg[k].rem = NW'(trial);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        t_stg s;
        for (int k = 0; k < DEPTH; k++) begin
            s = n_stg[k];
            if (!i_rst_n) begin
                s.valid = 1'b0;
            end
            r_stg[k] <= s;
        end
    end

    // Final stage: divide-by-zero check, rounding, sign and saturation.
    always_comb begin
        t_stg          s;
        logic [64:0]   mag;
        logic [64:0]   half;
        logic [64:0]   lim;
        s = r_stg[DEPTH-1];
        mag  = '0;
        half = 65'd1 << (FRAC_BITS - 1);
        if (s.is_mul) begin
            mag = (65'(s.prod) + half) >> FRAC_BITS;
        end else begin
            mag = 65'(s.num);
            if ({1'b0, s.rem, 1'b0} >= (NW+2)'(s.d)) begin
                mag = mag + 65'd1;
            end
        end
        lim = s.neg ? 65'h80000000 : 65'h7fffffff;
        o_res = s.simple;
        if (s.is_div && s.b_zero) begin
            o_res.result_value = '0;
            o_res.status = fxa_pkg::ST_DIV0;
        end else if (s.is_mul || s.is_div) begin
            if (mag > lim) begin
                o_res.result_value = s.neg ? 32'sh80000000 : 32'sh7fffffff;
                o_res.status = fxa_pkg::ST_OVF;
            end else begin
                o_res.result_value = s.neg ? -mag[31:0] : mag[31:0];
                o_res.status = fxa_pkg::ST_OK;
            end
        end
    end

    assign o_valid = r_stg[DEPTH-1].valid;

endmodule

[hdl/fixed_point_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu: signed 32-bit fixed-point arithmetic unit
// Add, subtract, rounded multiply and divide, compares, min/max and
// conversions, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Word
// request   in         i_start & !o_busy  i_req (operation, operand_a, operand_b)
// result    out        o_done             o_res (result_value, compare_flag, status)
//
// One word is accepted every cycle; o_busy is tied low.
// Between the accepting edge and o_done lie one front
// register, FRAC_BITS + 34 back stages set by the divider, which retires one
// quotient bit per stage, and the output register. All other operations
// travel the same path so results stay in order.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  fxa_pkg::t_in i_req,
    output logic         o_done,
    output fxa_pkg::t_out o_res
);

    logic          front_valid;
    fxa_pkg::t_cls front_cls;
    logic          back_valid;
    fxa_pkg::t_out back_res;
    logic          r_done;
    fxa_pkg::t_out r_res;

    // Nothing ever blocks the pipeline, so the block is never busy.
    assign o_busy = 1'b0;

    fxa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_req   (i_req),
        .o_valid (front_valid),
        .o_cls   (front_cls)
    );

    fxa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_cls   (front_cls),
        .o_valid (back_valid),
        .o_res   (back_res)
    );

    // Output register: each result is shown for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= back_valid;
        end
        r_res <= back_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_never_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.status <= fxa_pkg::ST_DIV0))
        else $error("illegal status");
    a_flag_only_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.compare_flag) |-> (o_res.status == fxa_pkg::ST_OK))
        else $error("flag with bad status");
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == fxa_pkg::ST_DIV0) |-> (o_res.result_value == 32'sd0))
        else $error("div0 nonzero result");
`endif

endmodule

[dv/fixed_point_alu_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_tb: self-checking bench for the fixed-point ALU
// A queue of request words feeds a bursty driver. A monitor checks every
// result word against an exact prediction made in 64-bit integer arithmetic.
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;

    localparam int FRAC_BITS = 8;
    localparam int LATENCY   = FRAC_BITS + 37;
    localparam int IDLE_LIMIT = 20000;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    fxa_pkg::t_in   req;
    logic  done;
    fxa_pkg::t_out  res;

    // Words waiting to be sent, and predicted results waiting to arrive.
    fxa_pkg::t_in   pending_words[$];
    fxa_pkg::t_out  expected_results[$];
    int    error_count;
    int    idle_cycles;
    bit    hold_off;
    int    burst_left;
    int    gap_left;

    fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_req   (req),
        .o_done  (done),
        .o_res   (res)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Clamp a 64-bit value into the signed 32-bit range, flagging overflow.
    function automatic void saturate(input longint v, output logic [31:0] r,
                                     inout logic [1:0] st);
        if (v > MAX32) begin
            r = MAX32[31:0];
            st = fxa_pkg::ST_OVF;
        end else if (v < MIN32) begin
            r = MIN32[31:0];
            st = fxa_pkg::ST_OVF;
        end else begin
            r = v[31:0];
        end
    endfunction

    // Exact prediction of one result word.
    function automatic fxa_pkg::t_out predict_alu(input fxa_pkg::t_in w);
        fxa_pkg::t_out o;
        longint a, b, p, m, n, d, q, r;
        logic [31:0] v;
        logic neg;
        a = longint'(w.operand_a);
        b = longint'(w.operand_b);
        o = '0;
        v = '0;
        o.status = fxa_pkg::ST_OK;
        case (fxa_pkg::t_op'(w.operation))
            fxa_pkg::OP_ADD: saturate(a + b, v, o.status);
            fxa_pkg::OP_SUB: saturate(a - b, v, o.status);
            fxa_pkg::OP_MUL: begin
                p = a * b;
                neg = p < 0;
                m = neg ? -p : p;
                m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                saturate(neg ? -m : m, v, o.status);
            end
            fxa_pkg::OP_DIV: begin
                if (b == 0) begin
                    o.status = fxa_pkg::ST_DIV0;
                end else begin
                    neg = (a < 0) != (b < 0);
                    n = (a < 0 ? -a : a) <<< FRAC_BITS;
                    d = b < 0 ? -b : b;
                    q = n / d;
                    r = n % d;
                    if (2 * r >= d) q++;
                    saturate(neg ? -q : q, v, o.status);
                end
            end
            fxa_pkg::OP_EQ: o.compare_flag = a == b;
            fxa_pkg::OP_NE: o.compare_flag = a != b;
            fxa_pkg::OP_LT: o.compare_flag = a < b;
            fxa_pkg::OP_GT: o.compare_flag = a > b;
            fxa_pkg::OP_LE: o.compare_flag = a <= b;
            fxa_pkg::OP_GE: o.compare_flag = a >= b;
            fxa_pkg::OP_MIN: v = (a > b) ? b[31:0] : a[31:0];
            fxa_pkg::OP_MAX: v = (a > b) ? a[31:0] : b[31:0];
            fxa_pkg::OP_INC: saturate(a + 1, v, o.status);
            fxa_pkg::OP_DEC: saturate(a - 1, v, o.status);
            // Arithmetic shift is floor division by the step size.
            fxa_pkg::OP_TO_INT: v = 32'(a >>> FRAC_BITS);
            default: saturate(a * (64'sd1 <<< FRAC_BITS), v, o.status);
        endcase
        o.result_value = v;
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return 32'($signed($urandom_range(0, 2047)) - 1024);
            4: return 32'($signed($urandom_range(0, 131071)) - 65536) << FRAC_BITS;
            5: return 32'($signed($urandom_range(0, 1023)) - 512) << $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic fxa_pkg::t_in make_word(input fxa_pkg::t_op op,
                                               input logic [31:0] a,
                                               input logic [31:0] b);
        fxa_pkg::t_in w;
        w.operation = op;
        w.operand_a = a;
        w.operand_b = b;
        return w;
    endfunction

    // Driver: bursts of random length separated by random gaps. The start
    // strobe is assigned once per edge, so back-to-back words stay high.
    // An accepted word is popped first, so the next word is always at the head.
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(predict_alu(req));
                void'(pending_words.pop_front());
            end
            if (hold_off || pending_words.size() == 0) begin
                start <= 1'b0;
            end else if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else begin
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
                start <= 1'b1;
                req <= pending_words[0];
            end
        end
    end

    // Monitor: compares every strobed result with the oldest prediction.
    always @(posedge clk) begin
        fxa_pkg::t_out want;
        if (rst_n) begin
            if ((start && !busy) || done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, res);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (res.result_value !== want.result_value) begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, want.result_value, res.result_value);
                        error_count++;
                    end
                    if (res.compare_flag !== want.compare_flag) begin
                        $display("%0t: compare_flag expected %b actual %b",
                                 $time, want.compare_flag, res.compare_flag);
                        error_count++;
                    end
                    if (res.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, res.status);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: the run fails if nothing moves for too long.
    always @(posedge clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        fxa_pkg::t_op op;
        start = 1'b0;
        req = '0;
        rst_n = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: every operation at the extremes, plus rounding
        // ties, division by zero, saturation and floor of negative values.
        for (int k = 0; k < 16; k++) begin
            pending_words.push_back(make_word(fxa_pkg::t_op'(k), 32'h7FFF_FFFF,
                                              32'h8000_0000));
        end
        pending_words.push_back(make_word(fxa_pkg::OP_MUL, 32'h0000_0180, 32'h0000_0080));
        pending_words.push_back(make_word(fxa_pkg::OP_MUL, 32'hFFFF_FF80, 32'h0000_0001));
        pending_words.push_back(make_word(fxa_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0200));
        pending_words.push_back(make_word(fxa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0000));
        pending_words.push_back(make_word(fxa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(fxa_pkg::OP_TO_INT, 32'hFFFF_FFFF, 32'h0));
        pending_words.push_back(make_word(fxa_pkg::OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(fxa_pkg::OP_FROM_INT, 32'hFF80_0000, 32'h0));
        pending_words.push_back(make_word(fxa_pkg::OP_EQ, 32'h8000_0000, 32'h8000_0000));

        // Let the directed part drain fully before any random word is sent.
        wait (pending_words.size() == 0);
        hold_off = 1'b1;
        wait (expected_results.size() == 0);
        hold_off = 1'b0;

        for (int k = 0; k < 1900; k++) begin
            op = fxa_pkg::t_op'($urandom_range(0, 15));
            pending_words.push_back(make_word(op, pick_operand(), pick_operand()));
        end
        wait (pending_words.size() == 0);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
